>>> design/kvt_pkg.sv
// Package: widths, character codes, event codes and shared types of the tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  // Capacities
  localparam int unsigned NAME_CAP  = 16;
  localparam int unsigned VALUE_CAP = 32;
  localparam int unsigned MAX_PAIRS = 16;

  // Counter widths, each wide enough to hold its capacity
  localparam int unsigned NAME_LEN_W  = $clog2(NAME_CAP + 1);
  localparam int unsigned VALUE_LEN_W = $clog2(VALUE_CAP + 1);
  localparam int unsigned PAIRS_W     = $clog2(MAX_PAIRS + 1);

  // Port field widths
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned EVENT_W  = 3;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned LENGTH_W = 6;
  localparam int unsigned COUNT_W  = 5;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [EVENT_W-1:0] {
    EV_NAME_CHAR  = 3'd0,
    EV_VALUE_CHAR = 3'd1,
    EV_PAIR       = 3'd2,
    EV_PAIR_END   = 3'd3,
    EV_LINE_END   = 3'd4,
    EV_ERROR      = 3'd5
  } kvt_event_e;

  typedef enum logic [2:0] {
    M_NAME     = 3'd0,
    M_AFTER_EQ = 3'd1,
    M_VALUE    = 3'd2,
    M_GAP      = 3'd3,
    M_SKIP     = 3'd4
  } kvt_mode_e;

  // Character class flags
  typedef struct packed {
    logic is_end;
    logic is_div;
    logic is_eq;
  } kvt_class_t;

  // One result item plus its emit flag
  typedef struct packed {
    logic                emit;
    kvt_event_e          event_res;
    logic [CHAR_W-1:0]   char_value;
    logic [INDEX_W-1:0]  pair_index;
    logic [LENGTH_W-1:0] length;
    logic [COUNT_W-1:0]  pair_count;
  } kvt_result_t;

endpackage

`default_nettype wire

>>> design/kvt_char_if.sv
// Interface: character request channel.
`timescale 1ns / 1ps
`default_nettype none

interface kvt_char_if;
  import kvt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

>>> design/kvt_event_if.sv
// Interface: event request channel.
`timescale 1ns / 1ps
`default_nettype none

interface kvt_event_if;
  import kvt_pkg::*;

  logic                valid;
  logic                ready;
  logic [EVENT_W-1:0]  event_res;
  logic [CHAR_W-1:0]   char_value;
  logic [INDEX_W-1:0]  pair_index;
  logic [LENGTH_W-1:0] length;
  logic [COUNT_W-1:0]  pair_count;

  modport source (output valid, output event_res, output char_value, output pair_index,
                  output length, output pair_count, input ready);
  modport sink   (input valid, input event_res, input char_value, input pair_index,
                  input length, input pair_count, output ready);
endinterface

`default_nettype wire

>>> design/key_value_line_tokenizer_top.sv
// Top level: input register, tokenizer state machine and event output register.
//
//  channel  dir  interface     payload
//  in_i     in   kvt_char_if   ch
//  out_o    out  kvt_event_if  event_res, char_value, pair_index, length, pair_count
//
// One character per cycle: a request lands in the input register, is classified and
// stepped through the state machine while it is held there, and its event (if any) is
// then loaded into the output register. The output register frees the input side
// as long as the event slot is empty or being taken; characters with no event never
// wait for it. Reset is asynchronous, active low, and starts a fresh line.
`timescale 1ns / 1ps
`default_nettype none

module key_value_line_tokenizer_top import kvt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  kvt_char_if.sink     in_i,
  kvt_event_if.source  out_o
);

  logic              in_valid_q;
  logic [CHAR_W-1:0] ch_q;
  logic              out_valid_q;
  kvt_result_t       out_q;
  kvt_class_t        cls;
  kvt_result_t       res;
  logic              step;

  kvt_classify u_classify (
    .ch_i  (ch_q),
    .cls_o (cls)
  );

  kvt_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ch_i   (ch_q),
    .cls_i  (cls),
    .res_o  (res)
  );

  // Advance the held character when its event has a free slot or it has none
  assign step       = in_valid_q && (!res.emit || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      ch_q <= in_i.ch;
    end
  end

  // Output register: load a new event, drop a taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_res  = out_q.event_res;
  assign out_o.char_value = out_q.char_value;
  assign out_o.pair_index = out_q.pair_index;
  assign out_o.length     = out_q.length;
  assign out_o.pair_count = out_q.pair_count;

endmodule

`default_nettype wire

>>> design/kvt_classify.sv
// Character classifier: divider, equal sign and line end flags.
`timescale 1ns / 1ps
`default_nettype none

module kvt_classify import kvt_pkg::*; (
  input  logic [CHAR_W-1:0] ch_i,
  output kvt_class_t        cls_o
);

  // Decode the character against the divider and line end sets
  always_comb begin
    cls_o.is_eq  = (ch_i == CH_EQUAL);
    cls_o.is_div = (ch_i == CH_EQUAL) || (ch_i == CH_SPACE) ||
                   (ch_i == CH_TAB)   || (ch_i == CH_COLON);
    cls_o.is_end = (ch_i == CH_CR) || (ch_i == CH_LF) || (ch_i == CH_NUL);
  end

endmodule

`default_nettype wire

>>> design/kvt_fsm.sv
// Tokenizer state machine: line mode, name and value lengths, pair count.
`timescale 1ns / 1ps
`default_nettype none

module kvt_fsm import kvt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [CHAR_W-1:0] ch_i,
  input  kvt_class_t        cls_i,
  output kvt_result_t       res_o
);

  kvt_mode_e              mode_q, mode_d;
  logic [NAME_LEN_W-1:0]  name_cnt_q, name_cnt_d;
  logic [VALUE_LEN_W-1:0] value_len_q, value_len_d;
  logic [PAIRS_W-1:0]     pairs_q, pairs_d;

  logic [NAME_LEN_W-1:0]  name_inc;
  logic [VALUE_LEN_W-1:0] value_inc;
  logic [PAIRS_W-1:0]     pairs_inc;
  logic                   name_full;
  logic                   value_full;
  logic                   name_first_full;
  logic                   value_first_full;
  logic                   pairs_full;

  // Increments and capacity checks
  assign name_inc         = name_cnt_q + NAME_LEN_W'(1);
  assign value_inc        = value_len_q + VALUE_LEN_W'(1);
  assign pairs_inc        = pairs_q + PAIRS_W'(1);
  assign name_full        = (name_inc >= NAME_LEN_W'(NAME_CAP));
  assign value_full       = (value_inc >= VALUE_LEN_W'(VALUE_CAP));
  assign name_first_full  = (NAME_LEN_W'(1) >= NAME_LEN_W'(NAME_CAP));
  assign value_first_full = (VALUE_LEN_W'(1) >= VALUE_LEN_W'(VALUE_CAP));
  assign pairs_full       = (pairs_inc >= PAIRS_W'(MAX_PAIRS));

  // Next state
  always_comb begin
    mode_d      = mode_q;
    name_cnt_d  = name_cnt_q;
    value_len_d = value_len_q;
    pairs_d     = pairs_q;
    if (cls_i.is_end) begin
      // Any line end starts a new line
      mode_d      = M_NAME;
      name_cnt_d  = '0;
      value_len_d = '0;
      pairs_d     = '0;
    end else begin
      case (mode_q)
        M_NAME: begin
          if (cls_i.is_eq) begin
            mode_d = (name_cnt_q == '0) ? M_SKIP : M_AFTER_EQ;
          end else if (cls_i.is_div || name_full) begin
            mode_d = M_SKIP;
          end else begin
            name_cnt_d = name_inc;
          end
        end
        M_AFTER_EQ: begin
          if (!cls_i.is_div) begin
            value_len_d = VALUE_LEN_W'(1);
            mode_d      = value_first_full ? M_SKIP : M_VALUE;
          end
        end
        M_VALUE: begin
          if (cls_i.is_div) begin
            pairs_d     = pairs_inc;
            name_cnt_d  = '0;
            value_len_d = '0;
            mode_d      = pairs_full ? M_SKIP : M_GAP;
          end else if (value_full) begin
            mode_d = M_SKIP;
          end else begin
            value_len_d = value_inc;
          end
        end
        M_GAP: begin
          if (!cls_i.is_div) begin
            name_cnt_d = NAME_LEN_W'(1);
            mode_d     = name_first_full ? M_SKIP : M_NAME;
          end
        end
        default: begin
          mode_d = M_SKIP;
        end
      endcase
    end
  end

  // Result for the current character
  always_comb begin
    res_o.emit       = 1'b0;
    res_o.event_res  = EV_ERROR;
    res_o.char_value = '0;
    res_o.pair_index = INDEX_W'(pairs_q);
    res_o.length     = '0;
    res_o.pair_count = '0;
    case (mode_q)
      M_NAME: begin
        res_o.emit = 1'b1;
        if (!cls_i.is_end && !cls_i.is_div && !name_full) begin
          res_o.event_res  = EV_NAME_CHAR;
          res_o.char_value = ch_i;
          res_o.length     = LENGTH_W'(name_inc);
          res_o.pair_count = COUNT_W'(pairs_q);
        end else if (cls_i.is_eq && name_cnt_q != '0) begin
          res_o.emit = 1'b0;
        end
      end
      M_AFTER_EQ: begin
        if (cls_i.is_end || (!cls_i.is_div && value_first_full)) begin
          res_o.emit = 1'b1;
        end else if (!cls_i.is_div) begin
          res_o.emit       = 1'b1;
          res_o.event_res  = EV_VALUE_CHAR;
          res_o.char_value = ch_i;
          res_o.length     = LENGTH_W'(1);
          res_o.pair_count = COUNT_W'(pairs_q);
        end
      end
      M_VALUE: begin
        res_o.emit = 1'b1;
        if (cls_i.is_end || cls_i.is_div) begin
          res_o.event_res  = (cls_i.is_end || pairs_full) ? EV_PAIR_END : EV_PAIR;
          res_o.length     = LENGTH_W'(value_len_q);
          res_o.pair_count = COUNT_W'(pairs_inc);
        end else if (!value_full) begin
          res_o.event_res  = EV_VALUE_CHAR;
          res_o.char_value = ch_i;
          res_o.length     = LENGTH_W'(value_inc);
          res_o.pair_count = COUNT_W'(pairs_q);
        end
      end
      M_GAP: begin
        if (cls_i.is_end) begin
          res_o.emit       = 1'b1;
          res_o.event_res  = EV_LINE_END;
          res_o.pair_count = COUNT_W'(pairs_q);
        end else if (!cls_i.is_div) begin
          res_o.emit = 1'b1;
          if (!name_first_full) begin
            res_o.event_res  = EV_NAME_CHAR;
            res_o.char_value = ch_i;
            res_o.length     = LENGTH_W'(1);
            res_o.pair_count = COUNT_W'(pairs_q);
          end
        end
      end
      default: begin
        res_o.emit = 1'b0;
      end
    endcase
  end

  // State registers, advanced once per processed character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= M_NAME;
      name_cnt_q  <= '0;
      value_len_q <= '0;
      pairs_q     <= '0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      name_cnt_q  <= name_cnt_d;
      value_len_q <= value_len_d;
      pairs_q     <= pairs_d;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for the tokenizer: directed and random character lines, checked event by event.
`timescale 1ns / 1ps
module tb;
  import kvt_pkg::*;

  localparam int PHASE_ITEMS   = 420;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int HOLD_AT       = 950;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DIRECTED_ROWS = 27;
  localparam int REPORT_LIMIT  = 10;

  // One directed character, optionally with its event typed in
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              pinned;
    kvt_result_t       want;
  } stim_row_t;

  localparam kvt_result_t NO_EVENT   = '0;
  localparam kvt_result_t LINE_ERROR = '{1'b1, EV_ERROR, 8'h00, 4'd0, 6'd0, 5'd0};
  localparam kvt_result_t HIGH_NAME  = '{1'b1, EV_NAME_CHAR, 8'hFF, 4'd0, 6'd1, 5'd0};

  logic clk_i = 1'b0;
  logic rst_ni;

  kvt_char_if  in_if ();
  kvt_event_if out_if ();

  key_value_line_tokenizer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Line state of the tokenizer as seen from the accepted requests
  kvt_mode_e              line_mode  = M_NAME;
  logic [NAME_LEN_W-1:0]  name_chars = '0;
  logic [VALUE_LEN_W-1:0] value_len  = '0;
  logic [PAIRS_W-1:0]     pairs_seen = '0;

  stim_row_t   offered_chars [$];
  kvt_result_t pending_events [$];
  int          accepted_chars = 0;
  int          issued         = 0;
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CH_NUL,   1'b1, LINE_ERROR},  // line end on an empty line
    '{CH_EQUAL, 1'b1, LINE_ERROR},  // empty name
    '{8'hFF,    1'b1, NO_EVENT},    // skipped
    '{CH_LF,    1'b1, NO_EVENT},    // line end closes the skip silently
    '{8'hFF,    1'b1, HIGH_NAME},
    '{CH_SPACE, 1'b1, LINE_ERROR},  // name not followed by '='
    '{CH_CR,    1'b1, NO_EVENT},
    '{8'h61,    1'b0, NO_EVENT},
    '{CH_EQUAL, 1'b0, NO_EVENT},
    '{CH_COLON, 1'b0, NO_EVENT},    // dividers between '=' and the value
    '{CH_TAB,   1'b0, NO_EVENT},
    '{8'h62,    1'b0, NO_EVENT},
    '{8'h01,    1'b0, NO_EVENT},
    '{CH_SPACE, 1'b0, NO_EVENT},    // pair done
    '{CH_EQUAL, 1'b0, NO_EVENT},    // extra divider between pairs
    '{8'h6B,    1'b0, NO_EVENT},
    '{CH_EQUAL, 1'b0, NO_EVENT},
    '{8'h80,    1'b0, NO_EVENT},
    '{CH_LF,    1'b0, NO_EVENT},    // pair done and line end
    '{8'h78,    1'b0, NO_EVENT},
    '{CH_EQUAL, 1'b0, NO_EVENT},
    '{CH_CR,    1'b1, LINE_ERROR},  // missing value
    '{8'h6E,    1'b0, NO_EVENT},
    '{CH_EQUAL, 1'b0, NO_EVENT},
    '{8'h7F,    1'b0, NO_EVENT},
    '{CH_COLON, 1'b0, NO_EVENT},    // trailing divider
    '{CH_NUL,   1'b0, NO_EVENT}     // plain line end
  };

  function automatic logic is_line_end(input logic [CHAR_W-1:0] c);
    return c == CH_CR || c == CH_LF || c == CH_NUL;
  endfunction

  function automatic logic is_divider(input logic [CHAR_W-1:0] c);
    return c == CH_EQUAL || c == CH_SPACE || c == CH_TAB || c == CH_COLON;
  endfunction

  function automatic void start_line();
    line_mode  = M_NAME;
    name_chars = '0;
    value_len  = '0;
    pairs_seen = '0;
  endfunction

  function automatic kvt_result_t make_event(input kvt_event_e ev,
                                             input logic [CHAR_W-1:0] c,
                                             input logic [PAIRS_W-1:0] idx,
                                             input logic [LENGTH_W-1:0] len,
                                             input logic [PAIRS_W-1:0] cnt);
    kvt_result_t r;
    r.emit       = 1'b1;
    r.event_res  = ev;
    r.char_value = c;
    r.pair_index = INDEX_W'(idx);
    r.length     = len;
    r.pair_count = COUNT_W'(cnt);
    return r;
  endfunction

  // Report a malformed line; skip its rest unless it is already over
  function automatic kvt_result_t flag_error(input logic line_over);
    logic [PAIRS_W-1:0] idx;
    idx = pairs_seen;
    if (line_over) start_line();
    else line_mode = M_SKIP;
    return make_event(EV_ERROR, '0, idx, '0, '0);
  endfunction

  // Advance the line state by one character and return its event, if any
  function automatic kvt_result_t tokenize_char(input logic [CHAR_W-1:0] c);
    kvt_result_t        r;
    logic               at_end;
    logic               at_div;
    logic [PAIRS_W-1:0] next_pairs;
    r      = NO_EVENT;
    at_end = is_line_end(c);
    at_div = is_divider(c);
    case (line_mode)
      M_NAME: begin
        if (at_end) begin
          r = flag_error(1'b1);
        end else if (c == CH_EQUAL) begin
          if (name_chars == 0) r = flag_error(1'b0);
          else line_mode = M_AFTER_EQ;
        end else if (at_div) begin
          r = flag_error(1'b0);
        end else begin
          name_chars = name_chars + 1'b1;
          if (name_chars >= NAME_CAP) r = flag_error(1'b0);
          else r = make_event(EV_NAME_CHAR, c, pairs_seen, LENGTH_W'(name_chars), pairs_seen);
        end
      end
      M_AFTER_EQ: begin
        if (at_end) begin
          r = flag_error(1'b1);
        end else if (!at_div) begin
          value_len = VALUE_LEN_W'(1);
          if (value_len >= VALUE_CAP) begin
            r = flag_error(1'b0);
          end else begin
            line_mode = M_VALUE;
            r = make_event(EV_VALUE_CHAR, c, pairs_seen, LENGTH_W'(value_len), pairs_seen);
          end
        end
      end
      M_VALUE: begin
        if (at_end || at_div) begin
          next_pairs = pairs_seen + 1'b1;
          if (at_end) begin
            r = make_event(EV_PAIR_END, '0, pairs_seen, LENGTH_W'(value_len), next_pairs);
            start_line();
          end else begin
            r = make_event((next_pairs >= MAX_PAIRS) ? EV_PAIR_END : EV_PAIR, '0,
                           pairs_seen, LENGTH_W'(value_len), next_pairs);
            pairs_seen = next_pairs;
            name_chars = '0;
            value_len  = '0;
            line_mode  = (next_pairs >= MAX_PAIRS) ? M_SKIP : M_GAP;
          end
        end else begin
          value_len = value_len + 1'b1;
          if (value_len >= VALUE_CAP) r = flag_error(1'b0);
          else r = make_event(EV_VALUE_CHAR, c, pairs_seen, LENGTH_W'(value_len), pairs_seen);
        end
      end
      M_GAP: begin
        if (at_end) begin
          r = make_event(EV_LINE_END, '0, pairs_seen, '0, pairs_seen);
          start_line();
        end else if (!at_div) begin
          name_chars = NAME_LEN_W'(1);
          line_mode  = M_NAME;
          if (name_chars >= NAME_CAP) r = flag_error(1'b0);
          else r = make_event(EV_NAME_CHAR, c, pairs_seen, LENGTH_W'(name_chars), pairs_seen);
        end
      end
      default: begin
        if (at_end) start_line();
        else line_mode = M_SKIP;
      end
    endcase
    return r;
  endfunction

  // Idle percentage per side: sender light first, then receiver light, then none
  function automatic int idle_pct(input logic receiver);
    case (accepted_chars / PHASE_ITEMS)
      0:       return receiver ? 59 : 20;
      1:       return receiver ? 20 : 59;
      default: return 0;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_divider();
    case ($urandom_range(3))
      0:       return CH_EQUAL;
      1:       return CH_SPACE;
      2:       return CH_TAB;
      default: return CH_COLON;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_line_end();
    case ($urandom_range(2))
      0:       return CH_CR;
      1:       return CH_LF;
      default: return CH_NUL;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_plain();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(255)); while (is_divider(c) || is_line_end(c));
    return c;
  endfunction

  // Mostly short fields, sometimes the longest legal one, at capacity, or empty
  function automatic int pick_len(input int cap);
    int r;
    r = $urandom_range(99);
    if (r < 8) return cap - 1;
    if (r < 14) return cap;
    if (r < 17) return 0;
    return $urandom_range(1, 6);
  endfunction

  // Offer one character and hold it until the request is taken
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic pinned = 1'b0,
                           input kvt_result_t want = '0);
    stim_row_t row;
    while ($urandom_range(99) < idle_pct(1'b0)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    row = '{c, pinned, want};
    offered_chars.push_back(row);
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    issued++;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // One random line: mostly well-formed pairs, otherwise noise
  task automatic send_line();
    int shape;
    int pairs;
    shape = $urandom_range(99);
    if (shape < 12) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(2))
          0:       send_char(CHAR_W'($urandom_range(255)));
          1:       send_char(pick_divider());
          default: send_char(pick_line_end());
        endcase
      end
    end else begin
      pairs = ($urandom_range(99) < 6) ? $urandom_range(MAX_PAIRS - 1, MAX_PAIRS + 2)
                                       : $urandom_range(1, 4);
      for (int p = 0; p < pairs; p++) begin
        repeat (pick_len(NAME_CAP)) send_char(pick_plain());
        send_char(CH_EQUAL);
        if ($urandom_range(99) < 30) repeat ($urandom_range(1, 2)) send_char(pick_divider());
        repeat (pick_len(VALUE_CAP)) send_char(pick_plain());
        if (p != pairs - 1) repeat ($urandom_range(1, 2)) send_char(pick_divider());
      end
      if ($urandom_range(99) < 25) repeat ($urandom_range(1, 2)) send_char(pick_divider());
      send_char(pick_line_end());
    end
  endtask

  // Predict the event of each accepted character
  always @(posedge clk_i) begin
    stim_row_t   row;
    kvt_result_t res;
    if (rst_ni && in_if.valid && in_if.ready) begin
      row = offered_chars.pop_front();
      res = tokenize_char(in_if.ch);
      if (row.pinned) res = row.want;
      if (res.emit) pending_events.push_back(res);
      accepted_chars <= accepted_chars + 1;
    end
  end

  // Compare each accepted event with the oldest prediction
  always @(posedge clk_i) begin
    kvt_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected event %0d at cycle %0d", out_if.event_res, cycle_count);
      end else begin
        want = pending_events.pop_front();
        if (out_if.event_res !== want.event_res || out_if.char_value !== want.char_value ||
            out_if.pair_index !== want.pair_index || out_if.length !== want.length ||
            out_if.pair_count !== want.pair_count) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"cycle %0d: got ev %0d ch %h idx %0d len %0d cnt %0d, ",
                      "expected ev %0d ch %h idx %0d len %0d cnt %0d"},
                     cycle_count, out_if.event_res, out_if.char_value, out_if.pair_index,
                     out_if.length, out_if.pair_count, want.event_res, want.char_value,
                     want.pair_index, want.length, want.pair_count);
        end
      end
    end
  end

  // Event side: random stalls, plus one long hold-off to back up the input
  initial begin
    int  stall_left;
    bit  stall_done;
    stall_left = 0;
    stall_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!stall_done && accepted_chars >= HOLD_AT) begin
        stall_done = 1'b1;
        stall_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Reset, directed table, random lines, then drain
  initial begin
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.ch    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].pinned, directed_rows[i].want);
    while (issued < DIRECTED_ROWS + RANDOM_ITEMS) send_line();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
